// ===== sv/zmodem_hex_header_parser_core_assert.svh =====
// Assertion macros for the hex header parser.
`ifndef ZMODEM_HEX_HEADER_PARSER_CORE_ASSERT_SVH
`define ZMODEM_HEX_HEADER_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge, off while reset is low.
`define ZHHP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("zhhp assertion failed");

// Property checked on every rising clock edge, reset included.
`define ZHHP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("zhhp assertion failed");

`else

`define ZHHP_ASSERT(lbl, clk, rstn, prop)
`define ZHHP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== sv/zhhp_pkg.sv =====
package zhhp_pkg;

  // Lead-in bytes
  localparam logic [7:0] LeadPad = 8'h2A;
  localparam logic [7:0] LeadDle = 8'h18;
  localparam logic [7:0] LeadHex = 8'h42;

  // Parse phase codes; digits occupy PhFirstDigit..PhLastDigit
  localparam int unsigned DigitCount = 14;
  localparam logic [4:0] PhHunt       = 5'd0;
  localparam logic [4:0] PhDle        = 5'd1;
  localparam logic [4:0] PhHex        = 5'd2;
  localparam logic [4:0] PhFirstDigit = 5'd3;
  localparam logic [4:0] PhLastDigit  = 5'(3 + DigitCount - 1);

  // Byte slots within the header digits
  localparam logic [2:0] SlotType    = 3'd0;
  localparam logic [2:0] SlotHdr0    = 3'd1;
  localparam logic [2:0] SlotHdr1    = 3'd2;
  localparam logic [2:0] SlotHdr2    = 3'd3;
  localparam logic [2:0] SlotHdr3    = 3'd4;
  localparam logic [2:0] SlotCrcHigh = 3'd5;

  // Result status codes
  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StCrc = 2'd1;
  localparam logic [1:0] StFmt = 2'd2;

  localparam logic [15:0] CrcPoly = 16'h1021;

  // ASCII hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30 : 8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61 : 8'h66]}) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c inside {[8'h41 : 8'h46]}) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  // CRC-16 byte update, MSB first, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/zmodem_hex_header_parser_core.sv =====
// ZMODEM hex header parser with CRC-16 check.
//
// Slave stream (s_axis_*): one received byte per item on tdata[7:0].
// Master stream (m_axis_*): one item per completed or broken header.
//   tdata  = frame type, header bytes ZP0..ZP3, CRC error count.
//   tuser  = status: ok, CRC mismatch, or non-hex digit (format error).
// Bytes outside a header (lead-in, CR/LF, noise) produce no item.
//
// Timing: a byte accepted into the input register is decoded there, and its
// result is registered in the output register, which drives m_axis_tvalid_o.
// One byte per cycle is sustained while the downstream side takes results;
// the input register and the output register make that.
// When the downstream side stalls with a result pending, the input
// register fills and s_axis_tready_o drops until the result is taken.
//
// Reset: the parser hunts for ZPAD, both registers are empty and the CRC
// error count is zero.
module zmodem_hex_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [7:0] frame_type, [15:8] header_byte0,
                                        // [23:16] header_byte1, [31:24] header_byte2,
                                        // [39:32] header_byte3, [55:40] crc_error_total
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import zhhp_pkg::*;

  `include "zmodem_hex_header_parser_core_assert.svh"

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state
  logic [4:0]  phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] hdr_q, hdr_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [15:0] cnt_q, cnt_d;

  // Output register
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic [1:0]  out_status_q;

  // Combinational decode results
  logic        out_free;
  logic        proc;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [7:0]  res_type;
  logic [31:0] res_hdr;
  logic [4:0]  hex_dec;
  logic [3:0]  digit_k;
  logic [2:0]  slot;
  logic [7:0]  dec_byte;
  logic [15:0] crc_fed;

  // Handshake: the decode step runs whenever the output register can take a result
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Decode helpers
  assign hex_dec  = hex_decode(in_byte_q);
  assign digit_k  = 4'(phase_q - PhFirstDigit);
  assign slot     = digit_k[3:1];
  assign dec_byte = {nib_q, hex_dec[3:0]};
  assign crc_fed  = crc_feed(crc_q, dec_byte);

  // Parser next state
  always_comb begin
    phase_d    = phase_q;
    nib_d      = nib_q;
    type_d     = type_q;
    hdr_d      = hdr_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    cnt_d      = cnt_q;
    res_valid  = 1'b0;
    res_status = StOk;
    res_type   = type_q;
    res_hdr    = hdr_q;
    if (proc) begin
      if (phase_q == PhHunt) begin
        if (in_byte_q == LeadPad) phase_d = PhDle;
      end else if (phase_q == PhDle) begin
        if (in_byte_q == LeadDle) begin
          phase_d = PhHex;
        end else if (in_byte_q != LeadPad) begin
          phase_d = PhHunt;
        end
      end else if (phase_q == PhHex) begin
        if (in_byte_q == LeadHex) begin
          phase_d  = PhFirstDigit;
          nib_d    = 4'd0;
          type_d   = 8'd0;
          hdr_d    = 32'd0;
          crc_d    = 16'd0;
          crc_hi_d = 8'd0;
        end else if (in_byte_q == LeadPad) begin
          phase_d = PhDle;
        end else begin
          phase_d = PhHunt;
        end
      end else if (phase_q > PhLastDigit) begin
        phase_d = PhHunt;
      end else if (!hex_dec[4]) begin
        // Non-hex digit: format error, fields zero
        phase_d    = PhHunt;
        res_valid  = 1'b1;
        res_status = StFmt;
        res_type   = 8'd0;
        res_hdr    = 32'd0;
      end else if (!digit_k[0]) begin
        nib_d   = hex_dec[3:0];
        phase_d = phase_q + 5'd1;
      end else begin
        phase_d = phase_q + 5'd1;
        case (slot)
          SlotType: begin
            type_d = dec_byte;
            crc_d  = crc_fed;
          end
          SlotHdr0: begin
            hdr_d[7:0] = dec_byte;
            crc_d      = crc_fed;
          end
          SlotHdr1: begin
            hdr_d[15:8] = dec_byte;
            crc_d       = crc_fed;
          end
          SlotHdr2: begin
            hdr_d[23:16] = dec_byte;
            crc_d        = crc_fed;
          end
          SlotHdr3: begin
            hdr_d[31:24] = dec_byte;
            crc_d        = crc_fed;
          end
          SlotCrcHigh: begin
            crc_hi_d = dec_byte;
          end
          default: begin
            // Last digit: compare received CRC and report
            phase_d   = PhHunt;
            res_valid = 1'b1;
            if ({crc_hi_q, dec_byte} != crc_q) begin
              res_status = StCrc;
              if (cnt_q != 16'hFFFF) cnt_d = cnt_q + 16'd1;
            end
          end
        endcase
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      nib_q    <= 4'd0;
      type_q   <= 8'd0;
      hdr_q    <= 32'd0;
      crc_q    <= 16'd0;
      crc_hi_q <= 8'd0;
      cnt_q    <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      type_q   <= type_d;
      hdr_q    <= hdr_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      cnt_q    <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q   <= {cnt_d, res_hdr, res_type};
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  // Assertions
  `ZHHP_ASSERT(a_fmt_fields_zero, clk_i, rst_ni,
    (out_valid_q && out_status_q == StFmt) |-> (out_data_q[39:0] == 40'd0))
  `ZHHP_ASSERT(a_cnt_monotonic, clk_i, rst_ni,
    ##1 (cnt_q >= $past(cnt_q)))
  `ZHHP_ASSERT(a_result_from_digit, clk_i, rst_ni,
    res_valid |-> (phase_q >= PhFirstDigit && phase_q <= PhLastDigit))
  `ZHHP_ASSERT_ALWAYS(a_phase_range, clk_i,
    (!rst_ni || phase_q <= PhLastDigit + 5'd1))
  `ZHHP_ASSERT(a_stall_holds_item, clk_i, rst_ni,
    !s_axis_tready_o |-> (in_valid_q && out_valid_q))

endmodule
